FILE: hdl/skst_pkg.sv
// shared types and constants for the sorted key set table
package skst_pkg;

    localparam int COLL_W  = 32;
    localparam int DOC_W   = 64;
    localparam int NODE_W  = 64;
    localparam int KEY_W   = COLL_W + DOC_W + NODE_W;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;
    localparam int REPORT_W = 8;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_REJECT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_SHIFT,
        S_INSERT,
        S_DONE
    } state_t;

endpackage

FILE: hdl/skst_ram.sv
// generic single write, single read ram with registered read data
module skst_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 255,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/sorted_key_set_table_unit.sv
// sorted key set table: binary search with insert and delete by entry shifting
// a key is found by binary search with up to ceil(log2(count+1)) probes, each a read and a compare;
//   an add then shifts the entries above the slot up and inserts the key, a remove shifts them down
// one beat at a time: in_stall is held from the accepted beat until the result is registered, and the
//   next beat can be taken while the result is shown; set by the single ram port pair and one comparator
// reset: entry count cleared, table contents undefined, no clearing pass
module sorted_key_set_table_unit #(
    parameter int CAPACITY = 255
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [skst_pkg::KIND_W-1:0]   kind,
    input  logic [skst_pkg::COLL_W-1:0]   collection,
    input  logic [skst_pkg::DOC_W-1:0]    document,
    input  logic [skst_pkg::NODE_W-1:0]   node_id,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [skst_pkg::STAT_W-1:0]   status,
    output logic                          found,
    output logic [skst_pkg::REPORT_W-1:0] position,
    output logic [skst_pkg::REPORT_W-1:0] entry_count
);

    import skst_pkg::*;

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [IW-1:0] CAP_I = IW'(CAPACITY);
    localparam logic [IW-1:0] ONE_I = IW'(1);

    state_t             state_reg, state_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [IW-1:0]      lo_reg, lo_next;
    logic [IW-1:0]      hi_reg, hi_next;
    logic [IW-1:0]      mid_reg, mid_next;
    logic               eq_reg, eq_next;
    logic [IW-1:0]      cnt_reg, cnt_next;
    logic [IW-1:0]      rp_reg, rp_next;
    logic [IW-1:0]      wa_reg, wa_next;
    logic               pend_reg, pend_next;
    logic               up_reg, up_next;
    logic [IW-1:0]      count_reg, count_next;
    logic [STAT_W-1:0]  res_status_reg, res_status_next;
    logic               res_found_reg, res_found_next;

    logic                out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic                found_reg, found_next;
    logic [REPORT_W-1:0] position_reg, position_next;
    logic [REPORT_W-1:0] entry_count_reg, entry_count_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [KEY_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [KEY_W-1:0] ram_rdata;

    logic [IW-1:0]    mid_calc;
    logic             key_gt;
    logic             key_eq;

    skst_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign key_gt   = key_reg > ram_rdata;
    assign key_eq   = key_reg == ram_rdata;

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign position    = position_reg;
    assign entry_count = entry_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pend_reg        <= 1'b0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pend_reg        <= pend_next;
            count_reg       <= count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        key_reg         <= key_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        mid_reg         <= mid_next;
        eq_reg          <= eq_next;
        cnt_reg         <= cnt_next;
        rp_reg          <= rp_next;
        wa_reg          <= wa_next;
        up_reg          <= up_next;
        res_status_reg  <= res_status_next;
        res_found_reg   <= res_found_next;
        status_reg      <= status_next;
        found_reg       <= found_next;
        position_reg    <= position_next;
        entry_count_reg <= entry_count_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        key_next         = key_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        mid_next         = mid_reg;
        eq_next          = eq_reg;
        cnt_next         = cnt_reg;
        rp_next          = rp_reg;
        wa_next          = wa_reg;
        pend_next        = pend_reg;
        up_next          = up_reg;
        count_next       = count_reg;
        res_status_next  = res_status_reg;
        res_found_next   = res_found_reg;
        status_next      = status_reg;
        found_next       = found_reg;
        position_next    = position_reg;
        entry_count_next = entry_count_reg;
        out_valid_next   = out_valid_reg && out_stall;

        ram_we    = 1'b0;
        ram_waddr = AW'(wa_reg);
        ram_wdata = ram_rdata;
        ram_raddr = AW'(mid_calc);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next       = kind;
                    key_next        = {collection, document, node_id};
                    lo_next         = '0;
                    hi_next         = count_reg;
                    eq_next         = 1'b0;
                    res_found_next  = 1'b0;
                    res_status_next = STATUS_OK;
                    if (collection == '0 || document == '0)
                    begin
                        res_status_next = STATUS_REJECT;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PROBE;
                    end
                end
            end

            S_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_calc;
                    state_next = S_CMP;
                end
                else
                begin
                    res_found_next = eq_reg;
                    state_next     = S_DONE;
                    if (kind_reg == KIND_ADD && !eq_reg)
                    begin
                        if (count_reg >= CAP_I)
                        begin
                            res_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            up_next    = 1'b1;
                            cnt_next   = count_reg - lo_reg;
                            rp_next    = count_reg - ONE_I;
                            pend_next  = 1'b0;
                            state_next = S_SHIFT;
                        end
                    end
                    else if (kind_reg == KIND_REMOVE && eq_reg)
                    begin
                        up_next    = 1'b0;
                        cnt_next   = count_reg - lo_reg - ONE_I;
                        rp_next    = lo_reg + ONE_I;
                        pend_next  = 1'b0;
                        state_next = S_SHIFT;
                    end
                end
            end

            S_CMP:
            begin
                if (key_gt)
                begin
                    lo_next = mid_reg + ONE_I;
                end
                else
                begin
                    hi_next = mid_reg;
                    eq_next = key_eq;
                end
                state_next = S_PROBE;
            end

            S_SHIFT:
            begin
                ram_we    = pend_reg;
                ram_raddr = AW'(rp_reg);
                if (cnt_reg != '0)
                begin
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg - ONE_I;
                    wa_next   = up_reg ? (rp_reg + ONE_I) : (rp_reg - ONE_I);
                    rp_next   = up_reg ? (rp_reg - ONE_I) : (rp_reg + ONE_I);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (up_reg)
                        begin
                            state_next = S_INSERT;
                        end
                        else
                        begin
                            count_next = count_reg - ONE_I;
                            state_next = S_DONE;
                        end
                    end
                end
            end

            S_INSERT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(lo_reg);
                ram_wdata  = key_reg;
                count_next = count_reg + ONE_I;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    found_next       = res_found_reg;
                    position_next    = (res_status_reg == STATUS_REJECT) ? '0
                                                                         : REPORT_W'(lo_reg);
                    entry_count_next = REPORT_W'(count_reg);
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_I)
        else $error("entry count above capacity");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_SHIFT || state_reg == S_INSERT))
        else $error("table written outside shift or insert");

    a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (lo_reg <= mid_reg && mid_reg < hi_reg))
        else $error("probe outside search window");

    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE || state_reg == S_CMP) |-> (hi_reg <= count_reg))
        else $error("search window beyond entry count");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INSERT) |-> (count_reg < CAP_I && lo_reg <= count_reg))
        else $error("insert without room");

endmodule
